// ===== rtl/psgl_pkg.sv =====
// Shared types and constants for the sequence gap and latency monitor.
`default_nettype none
package psgl_pkg;
  localparam int DEV_W = 4;
  localparam int SEQ_W = 64;
  localparam int LAT_W = 32;
  localparam int TS_W = 64;
  localparam int CNT_W = 32;
  localparam int MEAN_FRAC_BITS = 8;
  localparam int MEAN_W = LAT_W + MEAN_FRAC_BITS;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [DEV_W-1:0] device_index;
    logic [SEQ_W-1:0] seq_num;
    logic signed [LAT_W-1:0] latency;
    logic [TS_W-1:0] timestamp;
    logic end_of_tick;
  } in_item_t;

  typedef struct packed {
    logic [DEV_W-1:0] device_out;
    logic [SEQ_W-1:0] sequence_out;
    logic [TS_W-1:0] timestamp_out;
    logic gap_detected;
    logic [SEQ_W-1:0] gap_len;
    logic [CNT_W-1:0] gap_total;
    logic signed [MEAN_W-1:0] mean_latency;
    logic [CNT_W-1:0] sample_total;
    logic [CNT_W-1:0] frame_total;
  } out_item_t;
endpackage
`default_nettype wire

// ===== rtl/psgl_fifo.sv =====
// Two-entry queue between the front and the back.
`default_nettype none
module psgl_fifo
  import psgl_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic wr_valid,
  output logic wr_ready,
  input wire in_item_t wr_data,
  output logic rd_valid,
  input wire logic rd_ready,
  output in_item_t rd_data
);
  in_item_t mem [2];
  logic wptr, rptr;
  logic [1:0] count;
  logic do_wr, do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data = mem[rptr];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) wptr <= ~wptr;
      if (do_rd) rptr <= ~rptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/psgl_div.sv =====
// Iterative signed divider, truncating toward zero, one quotient bit a cycle.
`default_nettype none
module psgl_div
  import psgl_pkg::*;
#(
  parameter int NUM_W = 48
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic signed [NUM_W-1:0] numer,
  input wire logic [CNT_W-1:0] denom,
  output logic done,
  output logic signed [NUM_W-1:0] quot
);
  localparam int STEP_W = $clog2(NUM_W + 1);
  logic [NUM_W-1:0] mag, q;
  logic [CNT_W-1:0] rem;
  logic [CNT_W:0] trial;
  logic [CNT_W-1:0] den;
  logic neg, busy;
  logic [STEP_W-1:0] steps;

  assign trial = {rem, mag[NUM_W-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= STEP_W'(NUM_W);
        mag <= numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
        neg <= numer[NUM_W-1];
        den <= denom;
        rem <= '0;
        q <= '0;
      end else if (busy) begin
        // restoring step: shift in one numerator bit
        if (!trial[CNT_W]) begin
          rem <= trial[CNT_W-1:0];
          q <= {q[NUM_W-2:0], 1'b1};
        end else begin
          rem <= {rem[CNT_W-2:0], mag[NUM_W-1]};
          q <= {q[NUM_W-2:0], 1'b0};
        end
        mag <= {mag[NUM_W-2:0], 1'b0};
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = neg ? -$signed(q) : $signed(q);
endmodule
`default_nettype wire

// ===== rtl/psgl_back.sv =====
// Table update engine: gap check, counters and running mean.
`default_nettype none
module psgl_back
  import psgl_pkg::*;
#(
  parameter int NUM_DEVICES = 16
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire in_item_t in_data,
  output logic out_valid,
  input wire logic out_ready,
  output out_item_t out_data
);
  localparam int IDX_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int NUM_W = MEAN_W + 2;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_DIV = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  in_item_t item;
  logic [NUM_DEVICES-1:0] seen;
  logic [SEQ_W-1:0] last_seq_mem [NUM_DEVICES];
  logic [CNT_W-1:0] gap_mem [NUM_DEVICES];
  logic [CNT_W-1:0] smp_mem [NUM_DEVICES];
  logic signed [MEAN_W-1:0] mean_mem [NUM_DEVICES];
  logic [SEQ_W-1:0] last_seq_rd;
  logic [CNT_W-1:0] gap_rd, smp_rd;
  logic signed [MEAN_W-1:0] mean_rd;
  logic [CNT_W-1:0] frame_cnt;
  logic in_range, was_seen;
  logic [IDX_W-1:0] idx;
  logic [SEQ_W-1:0] diff;
  logic [CNT_W-1:0] gap_new, smp_new;
  logic signed [MEAN_W-1:0] scaled;
  logic signed [NUM_W-1:0] numer, quot;
  logic div_start, div_done;
  logic signed [MEAN_W-1:0] mean_new;

  assign in_range = (32'(in_data.device_index) < 32'(NUM_DEVICES));
  assign idx = IDX_W'(item.device_index);
  assign diff = item.seq_num - last_seq_rd;
  assign gap_new = (diff > SEQ_W'(1) && gap_rd != CNT_MAX) ? gap_rd + 1'b1 : gap_rd;
  assign smp_new = (smp_rd != CNT_MAX) ? smp_rd + 1'b1 : smp_rd;
  assign scaled = MEAN_W'($signed(item.latency)) <<< MEAN_FRAC_BITS;
  assign numer = NUM_W'(scaled) - NUM_W'(mean_rd);
  assign div_start = (state == S_DIV);
  assign mean_new = mean_rd + MEAN_W'(quot);
  assign in_ready = (state == S_IDLE) && !out_valid;

  psgl_div #(.NUM_W(NUM_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .numer(numer), .denom(smp_new),
    .done(div_done), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      last_seq_rd <= last_seq_mem[idx];
      gap_rd <= seen[idx] ? gap_mem[idx] : '0;
      smp_rd <= seen[idx] ? smp_mem[idx] : '0;
      mean_rd <= mean_mem[idx];
      was_seen <= seen[idx];
    end
    if (rst) begin
      state <= S_IDLE;
      seen <= '0;
      frame_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item <= in_data;
            if (in_data.end_of_tick && frame_cnt != CNT_MAX) frame_cnt <= frame_cnt + 1'b1;
            if (in_range) begin
              state <= S_READ;
            end else begin
              out_data <= '{in_data.device_index, in_data.seq_num, in_data.timestamp,
                            1'b0, '0, '0, '0, '0,
                            (in_data.end_of_tick && frame_cnt != CNT_MAX)
                            ? frame_cnt + 1'b1 : frame_cnt};
              out_valid <= 1'b1;
            end
          end
        end
        S_READ: state <= S_DIV;
        S_DIV: begin
          if (!was_seen) begin
            mean_rd <= scaled;
            smp_rd <= '0;
            gap_rd <= '0;
            last_seq_rd <= item.seq_num - SEQ_W'(1);
            state <= S_DONE;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_done) begin
            mean_rd <= mean_new;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // first frame: diff is 1, counts start from zero, mean already loaded
          seen[idx] <= 1'b1;
          last_seq_mem[idx] <= item.seq_num;
          gap_mem[idx] <= gap_new;
          smp_mem[idx] <= smp_new;
          mean_mem[idx] <= mean_rd;
          out_data.device_out <= item.device_index;
          out_data.sequence_out <= item.seq_num;
          out_data.timestamp_out <= item.timestamp;
          out_data.gap_detected <= (diff > SEQ_W'(1));
          out_data.gap_len <= (diff > SEQ_W'(1)) ? diff - SEQ_W'(1) : '0;
          out_data.gap_total <= gap_new;
          out_data.mean_latency <= mean_rd;
          out_data.sample_total <= smp_new;
          out_data.frame_total <= frame_cnt;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/per_stream_sequence_gap_latency_monitor_core.sv =====
// Top level: input queue feeding the per-device update engine.
// Path from input acceptance to result valid for a known device: queue, table read,
// 42-step mean divider, table write. A first frame skips the divider, and an item out
// of range goes from the queue straight to the result. The engine takes a new item only
// once the last result is taken; the queue holds up to two items meanwhile.
// Reset: rst synchronous, clears seen flags, counters, queue and output valid.
`default_nettype none
module per_stream_sequence_gap_latency_monitor_core
  import psgl_pkg::*;
#(
  parameter int NUM_DEVICES = 16
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire in_item_t in_data,
  output logic out_valid,
  input wire logic out_ready,
  output out_item_t out_data
);
  logic q_valid, q_ready;
  in_item_t q_data;

  psgl_fifo u_fifo (
    .clk(clk), .rst(rst), .wr_valid(in_valid), .wr_ready(in_ready),
    .wr_data(in_data), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  psgl_back #(.NUM_DEVICES(NUM_DEVICES)) u_back (
    .clk(clk), .rst(rst), .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule
`default_nettype wire
